// ===== hdl/coupled_oscillator_chain_derivative_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the oscillator chain derivative block
// Clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COUPLED_OSCILLATOR_CHAIN_DERIVATIVE_ASSERT_SVH
`define COUPLED_OSCILLATOR_CHAIN_DERIVATIVE_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define COCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition implies the consequence in the next cycle.
`define COCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cocd_pkg.sv =====
// ---------------------------------------------------------------------------
// cocd_pkg
// Shared widths, types and arithmetic helpers of the oscillator chain block.
// ---------------------------------------------------------------------------
package cocd_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 12;
    localparam int PROD_W = 2 * DATA_W;
    localparam int Q_W    = PROD_W + 1 - FRAC_W;
    localparam int ACC_W  = Q_W + 3;
    localparam int ADDR_W = 3;
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    localparam logic [ADDR_W-3:0]        REG_COUPLING_WEIGHT = '0;
    localparam logic signed [DATA_W-1:0] WEIGHT_RESET        = DATA_W'(819);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [Q_W-1:0]    t_q;

    // Coupling class of one node: none, one neighbor, two neighbors.
    typedef enum logic [1:0] {
        K_NONE,
        K_ONE,
        K_TWO
    } t_kind;

    // One derivative request handed from the front end to the back end.
    typedef struct packed {
        t_data x;
        t_data y;
        t_data g;
        t_data f;
        t_data n1r;
        t_data n1i;
        t_data n2r;
        t_data n2i;
        t_kind kind;
        logic  end_out;
        logic  run_last;
    } t_job;

    function automatic t_acc ext_data(input t_data v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic t_acc ext_q(input t_q v);
        return {{(ACC_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    // Clamp an accumulator to the signed data range.
    function automatic t_data sat_acc(input t_acc v);
        t_acc hi;
        t_acc lo;
        hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== hdl/cocd_queue.sv =====
// ---------------------------------------------------------------------------
// cocd_queue
// Small first-in first-out buffer of derivative requests.
// ---------------------------------------------------------------------------
module cocd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  cocd_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output cocd_pkg::t_job o_pop_job
);
    import cocd_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// ===== hdl/cocd_front.sv =====
// ---------------------------------------------------------------------------
// cocd_front
// Keeps the two-node window and turns arriving nodes into requests.
// ---------------------------------------------------------------------------
module cocd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cocd_pkg::t_data i_node_real,
    input  cocd_pkg::t_data i_node_imag,
    input  cocd_pkg::t_data i_node_gain,
    input  cocd_pkg::t_data i_node_freq,
    input  logic           i_chain_end_in,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output cocd_pkg::t_job  o_push_job
);
    import cocd_pkg::*;

    typedef enum logic [1:0] {
        W_EMPTY,
        W_FIRST,
        W_FULL
    } t_fill;

    t_fill r_fill;
    t_data r_held_real;
    t_data r_held_imag;
    t_data r_held_gain;
    t_data r_held_freq;
    t_data r_older_real;
    t_data r_older_imag;
    logic  r_pend;
    t_job  r_pend_job;

    logic  accept;
    logic  push_now;
    t_job  job_now;
    t_job  job_tail;

    assign o_in_ready = !r_pend && i_push_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign push_now   = accept && ((r_fill != W_EMPTY) || i_chain_end_in);

    always_comb begin
        if (r_fill == W_EMPTY) begin
            job_now.x        = i_node_real;
            job_now.y        = i_node_imag;
            job_now.g        = i_node_gain;
            job_now.f        = i_node_freq;
            job_now.n1r      = '0;
            job_now.n1i      = '0;
            job_now.kind     = K_NONE;
            job_now.end_out  = 1'b1;
            job_now.run_last = 1'b1;
        end else begin
            job_now.x        = r_held_real;
            job_now.y        = r_held_imag;
            job_now.g        = r_held_gain;
            job_now.f        = r_held_freq;
            job_now.n1r      = i_node_real;
            job_now.n1i      = i_node_imag;
            job_now.kind     = (r_fill == W_FIRST) ? K_ONE : K_TWO;
            job_now.end_out  = 1'b0;
            job_now.run_last = !i_chain_end_in;
        end
        job_now.n2r = r_older_real;
        job_now.n2i = r_older_imag;

        job_tail.x        = i_node_real;
        job_tail.y        = i_node_imag;
        job_tail.g        = i_node_gain;
        job_tail.f        = i_node_freq;
        job_tail.n1r      = r_held_real;
        job_tail.n1i      = r_held_imag;
        job_tail.n2r      = '0;
        job_tail.n2i      = '0;
        job_tail.kind     = K_ONE;
        job_tail.end_out  = 1'b1;
        job_tail.run_last = 1'b1;
    end

    assign o_push_valid = r_pend || push_now;
    assign o_push_job   = r_pend ? r_pend_job : job_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= W_EMPTY;
            r_pend <= 1'b0;
        end else begin
            if (r_pend && i_push_ready) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                case (r_fill)
                    W_EMPTY: begin
                        if (!i_chain_end_in) begin
                            r_held_real <= i_node_real;
                            r_held_imag <= i_node_imag;
                            r_held_gain <= i_node_gain;
                            r_held_freq <= i_node_freq;
                            r_fill      <= W_FIRST;
                        end
                    end
                    default: begin
                        if (i_chain_end_in) begin
                            r_pend     <= 1'b1;
                            r_pend_job <= job_tail;
                            r_fill     <= W_EMPTY;
                        end else begin
                            r_older_real <= r_held_real;
                            r_older_imag <= r_held_imag;
                            r_held_real  <= i_node_real;
                            r_held_imag  <= i_node_imag;
                            r_held_gain  <= i_node_gain;
                            r_held_freq  <= i_node_freq;
                            r_fill       <= W_FULL;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/cocd_back.sv =====
// ---------------------------------------------------------------------------
// cocd_back
// Evaluates one node derivative with a single shared multiplier.
// ---------------------------------------------------------------------------
module cocd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cocd_pkg::t_data i_weight,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  cocd_pkg::t_job  i_job,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cocd_pkg::t_data o_deriv_real,
    output cocd_pkg::t_data o_deriv_imag,
    output logic           o_chain_end_out,
    output logic           o_run_last
);
    import cocd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // One multiply per step, in this order.
    typedef enum logic [3:0] {
        P_XX,
        P_YY,
        P_AX,
        P_FY,
        P_FX,
        P_AY,
        P_WN1R,
        P_WN1I,
        P_WX,
        P_WY,
        P_WN2R,
        P_WN2I
    } t_step;

    t_state r_state;
    t_step  r_step;
    t_job   r_job;
    t_acc   r_acc_a;
    t_acc   r_dr;
    t_acc   r_di;
    logic   r_out_valid;
    t_data  r_deriv_real;
    t_data  r_deriv_imag;
    logic   r_chain_end;
    logic   r_run_last;

    t_data  a_sat;
    t_data  op_a;
    t_data  op_b;
    t_acc   qe;
    t_acc   qe_self;
    t_step  last_step;

    // Rounded Q-format product: add half an LSB, then floor.
    function automatic t_q mulq(input t_data a, input t_data b);
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W:0]   s;
        ea = {{(PROD_W-DATA_W){a[DATA_W-1]}}, a};
        eb = {{(PROD_W-DATA_W){b[DATA_W-1]}}, b};
        p  = ea * eb;
        s  = {p[PROD_W-1], p} + {{(PROD_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
        return s[PROD_W:FRAC_W];
    endfunction

    assign a_sat = sat_acc(r_acc_a);

    always_comb begin
        case (r_step)
            P_XX:    begin op_a = r_job.x;  op_b = r_job.x;   end
            P_YY:    begin op_a = r_job.y;  op_b = r_job.y;   end
            P_AX:    begin op_a = a_sat;    op_b = r_job.x;   end
            P_FY:    begin op_a = r_job.f;  op_b = r_job.y;   end
            P_FX:    begin op_a = r_job.f;  op_b = r_job.x;   end
            P_AY:    begin op_a = a_sat;    op_b = r_job.y;   end
            P_WN1R:  begin op_a = i_weight; op_b = r_job.n1r; end
            P_WN1I:  begin op_a = i_weight; op_b = r_job.n1i; end
            P_WX:    begin op_a = i_weight; op_b = r_job.x;   end
            P_WY:    begin op_a = i_weight; op_b = r_job.y;   end
            P_WN2R:  begin op_a = i_weight; op_b = r_job.n2r; end
            P_WN2I:  begin op_a = i_weight; op_b = r_job.n2i; end
            default: begin op_a = '0;       op_b = '0;        end
        endcase
    end

    assign qe = ext_q(mulq(op_a, op_b));
    // Inside the chain the node's own value counts twice.
    assign qe_self = (r_job.kind == K_TWO) ? (qe <<< 1) : qe;

    always_comb begin
        case (r_job.kind)
            K_NONE:  last_step = P_AY;
            K_ONE:   last_step = P_WY;
            default: last_step = P_WN2I;
        endcase
    end

    assign o_job_ready     = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_deriv_real    = r_deriv_real;
    assign o_deriv_imag    = r_deriv_imag;
    assign o_chain_end_out = r_chain_end;
    assign o_run_last      = r_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= P_XX;
            r_out_valid <= 1'b0;
        end else begin
            // In the done state the output register is refilled below.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_step  <= P_XX;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_step)
                        P_XX:    r_acc_a <= ext_data(r_job.g) - qe;
                        P_YY:    r_acc_a <= r_acc_a - qe;
                        P_AX:    r_dr    <= qe;
                        P_FY:    r_dr    <= r_dr - qe;
                        P_FX:    r_di    <= qe;
                        P_AY:    r_di    <= r_di + qe;
                        P_WN1R:  r_dr    <= r_dr + qe;
                        P_WN1I:  r_di    <= r_di + qe;
                        P_WX:    r_dr    <= r_dr - qe_self;
                        P_WY:    r_di    <= r_di - qe_self;
                        P_WN2R:  r_dr    <= r_dr + qe;
                        P_WN2I:  r_di    <= r_di + qe;
                        default: r_acc_a <= r_acc_a;
                    endcase
                    if (r_step == last_step) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= t_step'(r_step + 1'b1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_deriv_real <= sat_acc(r_dr);
                        r_deriv_imag <= sat_acc(r_di);
                        r_chain_end  <= r_job.end_out;
                        r_run_last   <= r_job.run_last;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/coupled_oscillator_chain_derivative.sv =====
// ---------------------------------------------------------------------------
// coupled_oscillator_chain_derivative
// Time derivative of a chain of Stuart-Landau oscillators with diffusive
// nearest-neighbor coupling, signed Q4.12 in and out.
// ---------------------------------------------------------------------------
// The back end takes one request at a time from the queue: it walks the
// products of the request through the single shared multiplier, which runs
// one product per cycle, then moves the result into the output register.
// The next request waits in the queue until the back end is idle again.
// Reset is synchronous and active low: the window and the queue empty, the
// output goes invalid and the coupling weight returns to 819 (about 0.2).
module coupled_oscillator_chain_derivative (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB-style configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cocd_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Node input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [cocd_pkg::DATA_W-1:0] i_node_real,
    input  logic signed [cocd_pkg::DATA_W-1:0] i_node_imag,
    input  logic signed [cocd_pkg::DATA_W-1:0] i_node_gain,
    input  logic signed [cocd_pkg::DATA_W-1:0] i_node_freq,
    input  logic                               i_chain_end_in,
    // Derivative output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cocd_pkg::DATA_W-1:0] o_deriv_real,
    output logic signed [cocd_pkg::DATA_W-1:0] o_deriv_imag,
    output logic                               o_chain_end_out,
    output logic                               o_run_last
);
    import cocd_pkg::*;

    t_data r_weight;
    logic  weight_sel;

    logic  push_valid;
    logic  push_ready;
    t_job  push_job;
    logic  pop_valid;
    logic  pop_ready;
    t_job  pop_job;

    // The coupling weight is the only register. It is written during the
    // access phase of an APB write and always answers without wait states.
    assign pready     = 1'b1;
    assign weight_sel = (paddr[ADDR_W-1:2] == REG_COUPLING_WEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (psel && penable && pwrite && pready && weight_sel) begin
            r_weight <= pwdata[DATA_W-1:0];
        end
    end

    // Reads return the weight sign-extended to the bus width.
    assign prdata = weight_sel ? {{(32-DATA_W){r_weight[DATA_W-1]}}, r_weight} : '0;

    // The front end holds the window of the last two nodes. Each node that
    // completes a neighborhood becomes a request carrying the node, its
    // neighbors and its coupling class; the last node of a chain of two or more
    // nodes yields two requests, the second held until the queue takes it.
    cocd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_node_real    (i_node_real),
        .i_node_imag    (i_node_imag),
        .i_node_gain    (i_node_gain),
        .i_node_freq    (i_node_freq),
        .i_chain_end_in (i_chain_end_in),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_job     (push_job)
    );

    // The queue lets the front end keep taking nodes while the back end is
    // busy with the arithmetic of an earlier one.
    cocd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    // The back end walks the products of one request through one multiplier
    // and leaves the saturated result in an output register, so the next
    // request can start while the previous result still waits.
    cocd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_weight        (r_weight),
        .i_job_valid     (pop_valid),
        .o_job_ready     (pop_ready),
        .i_job           (pop_job),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_deriv_real    (o_deriv_real),
        .o_deriv_imag    (o_deriv_imag),
        .o_chain_end_out (o_chain_end_out),
        .o_run_last      (o_run_last)
    );

endmodule

// ===== hdl/cocd_checker.sv =====
// ---------------------------------------------------------------------------
// cocd_checker
// Port-level checks of the oscillator chain derivative block.
// ---------------------------------------------------------------------------
`include "coupled_oscillator_chain_derivative_assert.svh"

module cocd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [cocd_pkg::ADDR_W-1:0]        paddr,
    input logic [31:0]                        pwdata,
    input logic [31:0]                        prdata,
    input logic                               pready,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic signed [cocd_pkg::DATA_W-1:0] i_node_real,
    input logic signed [cocd_pkg::DATA_W-1:0] i_node_imag,
    input logic signed [cocd_pkg::DATA_W-1:0] i_node_gain,
    input logic signed [cocd_pkg::DATA_W-1:0] i_node_freq,
    input logic                               i_chain_end_in,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [cocd_pkg::DATA_W-1:0] o_deriv_real,
    input logic signed [cocd_pkg::DATA_W-1:0] o_deriv_imag,
    input logic                               o_chain_end_out,
    input logic                               o_run_last
);
    import cocd_pkg::*;

    // The result of the last node always closes the run.
    `COCD_ASSERT_SAME(a_end_is_last, o_out_valid && o_chain_end_out, o_run_last, "end without run_last")

    // No result is shown in the first cycle after reset.
    `COCD_ASSERT_SAME(a_reset_empty, $rose(i_rst_n), !o_out_valid, "output valid out of reset")

    // A written weight reads back after the write, while the address still selects it.
    `COCD_ASSERT_NEXT(a_weight_rb, psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_COUPLING_WEIGHT), (paddr[ADDR_W-1:2] != REG_COUPLING_WEIGHT) || (prdata[DATA_W-1:0] == $past(pwdata[DATA_W-1:0])), "weight readback mismatch")

    // A stalled result keeps its payload.
    `COCD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_deriv_real) && $stable(o_deriv_imag) && $stable(o_run_last), "stalled result changed")

endmodule

bind coupled_oscillator_chain_derivative cocd_checker u_cocd_checker (.*);
